/* rtl/cas_pkg.sv */
package cas_pkg;

	localparam int unsigned FIELD_W = 64;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned CNT_W   = 11;
	localparam int unsigned CELLS_W = 7;
	localparam int unsigned LIM_W   = 4;
	localparam int unsigned CFG_AW  = 4;
	localparam int unsigned CFG_DW  = 11;

	typedef enum logic [CFG_AW-1:0] {
		REG_SURVIVE = 4'd0,
		REG_BIRTH   = 4'd1,
		REG_FRAME   = 4'd2,
		REG_CELLS   = 4'd3
	} cfg_reg_t;

	localparam logic [LIM_W-1:0]   SURVIVE_RST = 4'd1;
	localparam logic [LIM_W-1:0]   BIRTH_RST   = 4'd4;
	localparam logic [CNT_W-1:0]   FRAME_RST   = 11'd100;
	localparam logic [CELLS_W-1:0] CELLS_RST   = 7'd42;

	localparam logic [CNT_W-1:0]   FRAME_MIN = 11'd2;
	localparam logic [CNT_W-1:0]   FRAME_MAX = 11'd1024;
	localparam logic [CELLS_W-1:0] CELLS_MIN = 7'd3;

	typedef struct packed {
		logic [FIELD_W-1:0] bits;
		logic [IDX_W-1:0]   idx;
		logic               run_last;
		logic               frame_last;
	} res_t;

endpackage

/* rtl/cas_line_if.sv */
interface cas_line_if
	import cas_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] line_bits;

	modport source (output valid, output line_bits, input ready);
	modport sink   (input valid, input line_bits, output ready);
endinterface

/* rtl/cas_res_if.sv */
interface cas_res_if
	import cas_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] new_line_bits;
	logic [IDX_W-1:0]   line_index;
	logic               run_last;
	logic               frame_last;

	modport source (output valid, output new_line_bits, output line_index,
		output run_last, output frame_last, input ready);
	modport sink   (input valid, input new_line_bits, input line_index,
		input run_last, input frame_last, output ready);
endinterface

/* rtl/cas_cfg_if.sv */
interface cas_cfg_if
	import cas_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/cas_gen.sv */
module cas_gen
	import cas_pkg::*;
#(
	parameter int unsigned LINE_LEN = 64
) (
	input  logic [LINE_LEN-1:0] above,
	input  logic [LINE_LEN-1:0] mid,
	input  logic [LINE_LEN-1:0] below,
	input  logic [LINE_LEN-1:0] mask,
	input  logic [LIM_W-1:0]    survive_lim,
	input  logic [LIM_W-1:0]    birth_lim,
	output logic [LINE_LEN-1:0] nxt
);
	// cells past the active width read as alive
	logic [LINE_LEN-1:0] ea, em, eb;
	logic [LINE_LEN-1:0] al, ar, ml, mr, bl, br;

	assign ea = above | ~mask;
	assign em = mid | ~mask;
	assign eb = below | ~mask;

	assign al = {ea[LINE_LEN-2:0], 1'b1};
	assign ar = {1'b1, ea[LINE_LEN-1:1]};
	assign ml = {em[LINE_LEN-2:0], 1'b1};
	assign mr = {1'b1, em[LINE_LEN-1:1]};
	assign bl = {eb[LINE_LEN-2:0], 1'b1};
	assign br = {1'b1, eb[LINE_LEN-1:1]};

	for (genvar k = 0; k < LINE_LEN; k++) begin : g_cell
		logic [LIM_W-1:0] cnt;
		logic [LIM_W-1:0] lim;
		assign cnt = LIM_W'(al[k]) + LIM_W'(ea[k]) + LIM_W'(ar[k])
			+ LIM_W'(ml[k]) + LIM_W'(mr[k])
			+ LIM_W'(bl[k]) + LIM_W'(eb[k]) + LIM_W'(br[k]);
		assign lim = mid[k] ? survive_lim : birth_lim;
		assign nxt[k] = mask[k] & (cnt >= lim);
	end
endmodule

/* rtl/cave_automaton_step.sv */
// An accepted line is registered into the s1 stage, and its first result then into the output register.
// One line per cycle while the result side takes results; the final line of a frame yields two
// results, so the input waits while the second one sits in the hold slot.
// The first line of a frame only fills the line buffers and gives no result.
// Reset (arst_n low) clears the line counter, sets the upper line to all ones,
// loads the register defaults and empties the pipeline.
module cave_automaton_step
	import cas_pkg::*;
#(
	parameter int unsigned LINE_LEN = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	cas_line_if.sink      line,
	cas_res_if.source     result,
	cas_cfg_if.sink       cfg
);
	logic [LIM_W-1:0]   survive_q, birth_q;
	logic [CNT_W-1:0]   frame_q;
	logic [CELLS_W-1:0] cells_q;

	logic [LINE_LEN-1:0] upper_q, middle_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                valid_s1, two_s1;
	logic [LINE_LEN-1:0] up_s1, mid_s1, cur_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic out_v_q, hold_v_q;
	res_t out_q, hold_q;

	logic [CELLS_W-1:0]  width;
	logic [LINE_LEN-1:0] mask, cur, gen_a, gen_b;
	logic [CNT_W-1:0]    frame;
	logic                acc, last, adv, pop;
	res_t                res_a, res_b;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			survive_q <= SURVIVE_RST;
			birth_q   <= BIRTH_RST;
			frame_q   <= FRAME_RST;
			cells_q   <= CELLS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SURVIVE: survive_q <= cfg.data[LIM_W-1:0];
				REG_BIRTH:   birth_q   <= cfg.data[LIM_W-1:0];
				REG_FRAME:   frame_q   <= cfg.data[CNT_W-1:0];
				REG_CELLS:   cells_q   <= cfg.data[CELLS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cells_q < CELLS_MIN)
			width = CELLS_MIN;
		else if (cells_q > CELLS_W'(LINE_LEN))
			width = CELLS_W'(LINE_LEN);
		else
			width = cells_q;
		if (frame_q < FRAME_MIN)
			frame = FRAME_MIN;
		else if (frame_q > FRAME_MAX)
			frame = FRAME_MAX;
		else
			frame = frame_q;
	end

	for (genvar k = 0; k < LINE_LEN; k++) begin : g_mask
		assign mask[k] = CELLS_W'(k) < width;
	end

	assign cur  = line.line_bits[LINE_LEN-1:0] & mask;
	assign last = cnt_q >= (frame - 11'd1);

	assign pop  = out_v_q & result.ready;
	assign adv  = valid_s1 & ~hold_v_q & (~out_v_q | pop);
	assign line.ready = ~valid_s1 | adv;
	assign acc  = line.valid & line.ready;

	// line buffers and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '1;
			cnt_q   <= '0;
		end else if (acc) begin
			if (cnt_q == '0) begin
				upper_q <= '1;
				cnt_q   <= 11'd1;
			end else if (last) begin
				upper_q <= '1;
				cnt_q   <= '0;
			end else begin
				upper_q <= middle_q;
				cnt_q   <= cnt_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			middle_q <= cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line.ready) begin
			valid_s1 <= line.valid & (cnt_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			up_s1  <= upper_q;
			mid_s1 <= middle_q;
			cur_s1 <= cur;
			idx_s1 <= IDX_W'(cnt_q - 11'd1);
			two_s1 <= last;
		end
	end

	cas_gen #(.LINE_LEN(LINE_LEN)) u_gen_a (
		.above       (up_s1),
		.mid         (mid_s1),
		.below       (cur_s1),
		.mask        (mask),
		.survive_lim (survive_q),
		.birth_lim   (birth_q),
		.nxt         (gen_a)
	);

	cas_gen #(.LINE_LEN(LINE_LEN)) u_gen_b (
		.above       (mid_s1),
		.mid         (cur_s1),
		.below       ({LINE_LEN{1'b1}}),
		.mask        (mask),
		.survive_lim (survive_q),
		.birth_lim   (birth_q),
		.nxt         (gen_b)
	);

	always_comb begin
		res_a.bits       = FIELD_W'(gen_a);
		res_a.idx        = idx_s1;
		res_a.run_last   = ~two_s1;
		res_a.frame_last = 1'b0;
		res_b.bits       = FIELD_W'(gen_b);
		res_b.idx        = idx_s1 + 10'd1;
		res_b.run_last   = 1'b1;
		res_b.frame_last = 1'b1;
	end

	// output register plus a hold slot for the second result of a final line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else if (~out_v_q | pop) begin
			if (hold_v_q) begin
				out_v_q  <= 1'b1;
				hold_v_q <= 1'b0;
			end else begin
				out_v_q  <= adv;
				hold_v_q <= adv & two_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (~out_v_q | pop) begin
			if (hold_v_q) begin
				out_q <= hold_q;
			end else if (adv) begin
				out_q  <= res_a;
				hold_q <= res_b;
			end
		end
	end

	assign result.valid         = out_v_q;
	assign result.new_line_bits = out_q.bits;
	assign result.line_index    = out_q.idx;
	assign result.run_last      = out_q.run_last;
	assign result.frame_last    = out_q.frame_last;
endmodule

/* test/testbench.sv */
module testbench;
	import cas_pkg::*;

	localparam int unsigned LINE_LEN = FIELD_W;
	localparam logic [CFG_AW-1:0] REG_SPARE = 4'hF;
	localparam int RANDOM_LINES = 340;
	localparam int SETTLE_CYCLES = 4;

	logic clk;
	logic arst_n;

	cas_line_if line ();
	cas_res_if  result ();
	cas_cfg_if  cfg ();

	cave_automaton_step dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line),
		.result (result),
		.cfg    (cfg)
	);

	// grid state and registers as the block should hold them
	logic [LIM_W-1:0]   survive_lim;
	logic [LIM_W-1:0]   birth_lim;
	logic [CNT_W-1:0]   frame_reg;
	logic [CELLS_W-1:0] cells_reg;
	logic [FIELD_W-1:0] upper_row;
	logic [FIELD_W-1:0] middle_row;
	logic [CNT_W-1:0]   row_count;

	logic [FIELD_W-1:0] lines_to_send[$];
	res_t               expected_lines[$];

	bit          calm;
	bit          line_fire;
	int unsigned line_gap;
	int unsigned ready_gap;
	int          mismatches;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [FIELD_W-1:0] random_line();
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		int unsigned r;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		r = $urandom_range(0, 19);
		if (r < 10)
			return a;
		if (r < 14)
			return a & b;
		if (r < 18)
			return a | b;
		if (r == 18)
			return {FIELD_W{1'b1}};
		return '0;
	endfunction

	// off-grid neighbors count as alive
	function automatic int alive_at(input logic [FIELD_W-1:0] row, input int col, input int w);
		if (col < 0 || col >= w)
			return 1;
		return int'(row[col]);
	endfunction

	function automatic logic [FIELD_W-1:0] evolve(input logic [FIELD_W-1:0] above,
		input logic [FIELD_W-1:0] mid, input logic [FIELD_W-1:0] below, input int w);
		logic [FIELD_W-1:0] nxt;
		int n;
		int lim;
		int k;
		nxt = '0;
		for (k = 0; k < w; k++) begin
			n = alive_at(above, k - 1, w) + alive_at(above, k, w) + alive_at(above, k + 1, w)
				+ alive_at(mid, k - 1, w) + alive_at(mid, k + 1, w)
				+ alive_at(below, k - 1, w) + alive_at(below, k, w) + alive_at(below, k + 1, w);
			lim = (alive_at(mid, k, w) != 0) ? int'(survive_lim) : int'(birth_lim);
			if (n >= lim)
				nxt[k] = 1'b1;
		end
		return nxt;
	endfunction

	function automatic void step_grid(input logic [FIELD_W-1:0] raw);
		int w;
		logic [FIELD_W-1:0] keep;
		logic [FIELD_W-1:0] cur;
		logic [CNT_W-1:0] span;
		res_t r;
		if (cells_reg < CELLS_MIN)
			w = int'(CELLS_MIN);
		else if (int'(cells_reg) > LINE_LEN)
			w = LINE_LEN;
		else
			w = int'(cells_reg);
		keep = (w >= FIELD_W) ? {FIELD_W{1'b1}} : ((64'd1 << w) - 64'd1);
		cur = raw & keep;
		if (frame_reg < FRAME_MIN)
			span = FRAME_MIN;
		else if (frame_reg > FRAME_MAX)
			span = FRAME_MAX;
		else
			span = frame_reg;
		if (row_count == '0) begin
			upper_row = {FIELD_W{1'b1}};
			middle_row = cur;
			row_count = 11'd1;
		end else begin
			r.bits = evolve(upper_row, middle_row, cur, w) & keep;
			r.idx = IDX_W'(row_count - 11'd1);
			r.frame_last = 1'b0;
			if (row_count >= span - 11'd1) begin
				// last line of the frame: also emit the new state of that line
				r.run_last = 1'b0;
				expected_lines.push_back(r);
				r.bits = evolve(middle_row, cur, {FIELD_W{1'b1}}, w) & keep;
				r.idx = row_count[IDX_W-1:0];
				r.run_last = 1'b1;
				r.frame_last = 1'b1;
				expected_lines.push_back(r);
				upper_row = {FIELD_W{1'b1}};
				middle_row = '0;
				row_count = '0;
			end else begin
				r.run_last = 1'b1;
				expected_lines.push_back(r);
				upper_row = middle_row;
				middle_row = cur;
				row_count = row_count + 11'd1;
			end
		end
	endfunction

	function automatic void load_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] d);
		case (idx)
			REG_SURVIVE: survive_lim = d[LIM_W-1:0];
			REG_BIRTH:   birth_lim = d[LIM_W-1:0];
			REG_FRAME:   frame_reg = d[CNT_W-1:0];
			REG_CELLS:   cells_reg = d[CELLS_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void compare_new_line();
		res_t got;
		res_t want;
		got.bits = result.new_line_bits;
		got.idx = result.line_index;
		got.run_last = result.run_last;
		got.frame_last = result.frame_last;
		if (expected_lines.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected item: bits %h idx %0d run_last %b frame_last %b",
					got.bits, got.idx, got.run_last, got.frame_last);
			mismatches++;
		end else begin
			want = expected_lines.pop_front();
			if (got.bits !== want.bits || got.idx !== want.idx
				|| got.run_last !== want.run_last || got.frame_last !== want.frame_last) begin
				if (mismatches < 10)
					$display("mismatch: bits %h idx %0d run_last %b frame_last %b, %s %h %0d %b %b",
						got.bits, got.idx, got.run_last, got.frame_last, "expected",
						want.bits, want.idx, want.run_last, want.frame_last);
				mismatches++;
			end
		end
	endfunction

	always @(posedge clk) begin
		line_fire = (line.valid === 1'b1) && (line.ready === 1'b1);
		if (line_fire)
			step_grid(line.line_bits);
		if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
			load_reg(cfg.index, cfg.data);
		if (result.valid === 1'b1 && result.ready === 1'b1)
			compare_new_line();
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			line.valid <= 1'b0;
		end else if (!line.valid || line_fire) begin
			if (line_gap != 0) begin
				line_gap--;
				line.valid <= 1'b0;
			end else if (lines_to_send.size() != 0) begin
				line.valid <= 1'b1;
				line.line_bits <= lines_to_send.pop_front();
				line_gap = pick_gap();
			end else begin
				line.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (ready_gap != 0) begin
			ready_gap--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
			ready_gap = pick_gap();
		end
	end

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (lines_to_send.size() != 0 || line.valid === 1'b1 || expected_lines.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// finish a partial frame so the line width can change at a frame boundary
	task automatic close_frame();
		if (row_count != '0) begin
			write_reg(REG_FRAME, FRAME_MIN);
			lines_to_send.push_back(random_line());
			drain();
		end
	endtask

	initial begin
		int n;
		int random_sent;
		line.valid = 1'b0;
		line.line_bits = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		line_gap = 0;
		ready_gap = 0;
		mismatches = 0;
		random_sent = 0;
		survive_lim = SURVIVE_RST;
		birth_lim = BIRTH_RST;
		frame_reg = FRAME_RST;
		cells_reg = CELLS_RST;
		upper_row = {FIELD_W{1'b1}};
		middle_row = '0;
		row_count = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset values, partial frame
		lines_to_send.push_back({FIELD_W{1'b1}});
		lines_to_send.push_back('0);
		lines_to_send.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		drain();
		// frame length lowered below the current row: next line closes the frame
		write_reg(REG_FRAME, 11'd1);
		lines_to_send.push_back(64'h5555_5555_5555_5555);
		drain();
		lines_to_send.push_back({FIELD_W{1'b1}});
		lines_to_send.push_back('0);
		lines_to_send.push_back('0);
		lines_to_send.push_back({FIELD_W{1'b1}});
		drain();
		write_reg(REG_CELLS, 11'd0);
		write_reg(REG_SURVIVE, 11'd0);
		write_reg(REG_BIRTH, 11'd15);
		lines_to_send.push_back(64'h5);
		lines_to_send.push_back(64'hFFFF_FFFF_FFFF_FFF2);
		drain();
		write_reg(REG_CELLS, 11'd127);
		write_reg(REG_SURVIVE, 11'd9);
		write_reg(REG_BIRTH, 11'd9);
		write_reg(REG_FRAME, 11'd0);
		lines_to_send.push_back({FIELD_W{1'b1}});
		lines_to_send.push_back(64'h8000_0000_0000_0001);
		drain();
		write_reg(REG_SURVIVE, 11'd8);
		write_reg(REG_BIRTH, 11'd0);
		write_reg(REG_CELLS, 11'd64);
		write_reg(REG_FRAME, 11'd3);
		write_reg(REG_SPARE, 11'h7FF);
		lines_to_send.push_back(64'h8000_0000_0000_0000);
		lines_to_send.push_back(64'h0123_4567_89AB_CDEF);
		lines_to_send.push_back(64'hFEDC_BA98_7654_3210);
		drain();
		write_reg(REG_SURVIVE, 11'd15);
		write_reg(REG_BIRTH, 11'd8);
		write_reg(REG_CELLS, 11'd3);
		write_reg(REG_FRAME, 11'd4);
		lines_to_send.push_back(64'h6);
		lines_to_send.push_back(64'h1);
		lines_to_send.push_back(64'h4);
		lines_to_send.push_back(64'h7);
		drain();

		while (random_sent < RANDOM_LINES) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) begin
				close_frame();
				write_reg(REG_CELLS, ($urandom_range(0, 4) != 0) ?
					11'($urandom_range(3, 64)) : 11'($urandom_range(0, 2047)));
			end
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_SURVIVE, ($urandom_range(0, 6) != 0) ?
					11'($urandom_range(0, 9)) : 11'($urandom_range(0, 2047)));
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_BIRTH, ($urandom_range(0, 6) != 0) ?
					11'($urandom_range(0, 9)) : 11'($urandom_range(0, 2047)));
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_FRAME, 11'($urandom_range(0, 2047)));
			else
				write_reg(REG_FRAME, 11'($urandom_range(2, 12)));
			n = $urandom_range(1, 40);
			repeat (n) lines_to_send.push_back(random_line());
			random_sent += n;
			drain();
		end

		// largest frame, set by a register value above the maximum
		calm = 1'b1;
		close_frame();
		write_reg(REG_CELLS, 11'($urandom_range(3, 64)));
		write_reg(REG_SURVIVE, 11'($urandom_range(2, 5)));
		write_reg(REG_BIRTH, 11'($urandom_range(3, 6)));
		write_reg(REG_FRAME, 11'd2047);
		repeat (1030) lines_to_send.push_back(random_line());
		drain();

		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#24000000;
		$display("testbench: errors");
		$finish;
	end

endmodule

/* cave_automaton_step.f */
rtl/cas_pkg.sv
rtl/cas_line_if.sv
rtl/cas_res_if.sv
rtl/cas_cfg_if.sv
rtl/cas_gen.sv
rtl/cave_automaton_step.sv
test/testbench.sv
